// ----- rtl/pcht_pkg.sv -----
// shared types, constants and helpers for the page cache hash table
// depends on nothing; the top level, controller, datapath and testbench import it
`default_nettype none

package pcht_pkg;

   // sizing
   localparam int HASH_WIDTH = 11;
   localparam int PAGE_BITS  = 12;
   localparam int SLOT_COUNT = 512;

   localparam int BUCKETS   = 1 << HASH_WIDTH;
   localparam int SLOT_W    = $clog2(SLOT_COUNT);
   localparam int LINK_W    = SLOT_W + 1;
   localparam int CLR_COUNT = (BUCKETS > SLOT_COUNT) ? BUCKETS : SLOT_COUNT;
   localparam int CLR_W     = $clog2(CLR_COUNT);

   localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(SLOT_COUNT);
   localparam logic [15:0]       REF_MAX  = 16'hFFFF;

   // request command codes
   localparam logic [1:0] CMD_FIND   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_RSVD   = 2'd3;

   // response status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;

   // one page slot record
   typedef struct packed {
      logic [15:0]       inode;
      logic [31:0]       offset;
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
      logic [15:0]       refs;
      logic              cached;
   } slot_rec_type;

   // controller states
   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_FHEAD,
      S_FRD,
      S_FCMP,
      S_SCHK,
      S_ABKT,
      S_AWR,
      S_PRD,
      S_PWRP,
      S_RUNL,
      S_RPV,
      S_RWN,
      S_RBKT,
      S_RBWR,
      S_DONE
   } ctrl_state_type;

   // datapath micro operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_BKT_RD,
      OP_LOAD_HEAD,
      OP_MISS,
      OP_SLOT_RD_REQ,
      OP_SLOT_RD_PTR,
      OP_SLOT_RD_PREV,
      OP_HIT,
      OP_ADVANCE,
      OP_HOLD_REC,
      OP_HOLD_REM,
      OP_ILLEGAL,
      OP_ADD_WR,
      OP_SET_PREV,
      OP_REM_WR,
      OP_SET_NEXT,
      OP_BKT_FIX,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_find;
      logic is_add;
      logic is_rem;
      logic cached;
      logic match;
      logic ptr_nil;
      logic walk_limit;
      logic head_nil;
      logic nx_nil;
      logic pv_nil;
      logic out_busy;
   } dp_stat_type;

   // bucket index of a page
   function automatic logic [HASH_WIDTH-1:0] pcht_hash(input logic [15:0] key,
                                                       input logic [31:0] off);
      logic [31:0] s;
      logic [31:0] h;
      s = 32'(key) + (off >> PAGE_BITS);
      h = s + (s >> HASH_WIDTH);
      return h[HASH_WIDTH-1:0];
   endfunction

   function automatic logic pcht_is_nil(input logic [LINK_W-1:0] link);
      return link >= LINK_NIL;
   endfunction

   // saturating reference bump
   function automatic logic [15:0] pcht_bump(input logic [15:0] refs);
      return (refs == REF_MAX) ? refs : refs + 16'd1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pcht_if.sv -----
// request and response channel interfaces of the page cache hash table
// depends on nothing
`default_nettype none

interface pcht_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [8:0]  slot;
   logic [15:0] inode_key;
   logic [31:0] file_offset;

   modport source (output valid, cmd, slot, inode_key, file_offset, input ready);
   modport sink   (input valid, cmd, slot, inode_key, file_offset, output ready);
endinterface

interface pcht_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [8:0]  found_slot;
   logic [15:0] ref_count;
   logic [9:0]  cached_pages;

   modport source (output valid, status, found_slot, ref_count, cached_pages, input ready);
   modport sink   (input valid, status, found_slot, ref_count, cached_pages, output ready);
endinterface

`default_nettype wire

// ----- rtl/page_cache_hash_table_top.sv -----
// Page cache hash table: pages keyed by inode and file offset live in a pool of
// 512 slots, chained per bucket (2048 buckets) in doubly linked lists. After
// reset the block runs a clearing pass over the bucket and slot memories before
// it takes its first request. Commands run one at a time; a find does one slot
// memory read and compare per chain entry. A finished response sits in an output
// register, so the next request is taken while it waits.
// depends on pcht_pkg, pcht_if, pcht_ctrl and pcht_datapath
`default_nettype none

module page_cache_hash_table_top
   import pcht_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   pcht_req_if.sink   req_ch,
   pcht_rsp_if.source rsp_ch
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   pcht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   pcht_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .req_cmd          (req_ch.cmd),
      .req_slot         (req_ch.slot),
      .req_inode_key    (req_ch.inode_key),
      .req_file_offset  (req_ch.file_offset),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_status       (rsp_ch.status),
      .rsp_found_slot   (rsp_ch.found_slot),
      .rsp_ref_count    (rsp_ch.ref_count),
      .rsp_cached_pages (rsp_ch.cached_pages)
   );

endmodule

`default_nettype wire

// ----- rtl/pcht_datapath.sv -----
// datapath: bucket head memory, slot record memory, walk pointer and result registers
// depends on pcht_pkg
`default_nettype none

module pcht_datapath
   import pcht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [8:0]  req_slot,
   input  wire logic [15:0] req_inode_key,
   input  wire logic [31:0] req_file_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [8:0]       rsp_found_slot,
   output logic [15:0]      rsp_ref_count,
   output logic [9:0]       rsp_cached_pages
);

   // memories
   logic [LINK_W-1:0] bkt_mem [BUCKETS];
   slot_rec_type      slot_mem [SLOT_COUNT];

   logic                  b_we, b_re, s_we, s_re;
   logic [HASH_WIDTH-1:0] b_waddr, b_raddr;
   logic [LINK_W-1:0]     b_wdata;
   logic [SLOT_W-1:0]     s_waddr, s_raddr;
   slot_rec_type          s_wdata;
   logic [LINK_W-1:0]     b_rdata_ff;
   slot_rec_type          s_rdata_ff;

   // working registers
   logic [CLR_W-1:0]      clr_ff, clr_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [15:0]           key_ff, key_in;
   logic [31:0]           off_ff, off_in;
   logic [HASH_WIDTH-1:0] hash_ff, hash_in;
   logic [LINK_W-1:0]     ptr_ff, ptr_in;
   logic [LINK_W-1:0]     steps_ff, steps_in;
   slot_rec_type          rec_ff, rec_in;
   logic [9:0]            total_ff, total_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [15:0]           res_refs_ff, res_refs_in;
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_status_ff, out_status_in;
   logic [SLOT_W-1:0]     out_slot_ff, out_slot_in;
   logic [15:0]           out_refs_ff, out_refs_in;
   logic [9:0]            out_total_ff, out_total_in;

   logic [LINK_W-1:0] slot_link;
   slot_rec_type      mod_rec;

   assign slot_link = {1'b0, slot_ff};

   // bucket head memory
   always_ff @(posedge clock) begin
      if (b_we) begin
         bkt_mem[b_waddr] <= b_wdata;
      end
      if (b_re) begin
         b_rdata_ff <= bkt_mem[b_raddr];
      end
   end

   // slot record memory
   always_ff @(posedge clock) begin
      if (s_we) begin
         slot_mem[s_waddr] <= s_wdata;
      end
      if (s_re) begin
         s_rdata_ff <= slot_mem[s_raddr];
      end
   end

   // micro operation decode
   always_comb begin
      b_we          = 1'b0;
      b_re          = 1'b0;
      b_waddr       = hash_ff;
      b_raddr       = hash_ff;
      b_wdata       = LINK_NIL;
      s_we          = 1'b0;
      s_re          = 1'b0;
      s_waddr       = slot_ff;
      s_raddr       = slot_ff;
      s_wdata       = s_rdata_ff;
      mod_rec       = s_rdata_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      key_in        = key_ff;
      off_in        = off_ff;
      hash_in       = hash_ff;
      ptr_in        = ptr_ff;
      steps_in      = steps_ff;
      rec_in        = rec_ff;
      total_in      = total_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_refs_in   = res_refs_ff;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_refs_in   = out_refs_ff;
      out_total_in  = out_total_ff;

      unique case (cmd.op)
         OP_CLEAR: begin
            b_we    = ({1'b0, clr_ff} < (CLR_W + 1)'(BUCKETS));
            b_waddr = clr_ff[HASH_WIDTH-1:0];
            b_wdata = LINK_NIL;
            s_we    = ({1'b0, clr_ff} < (CLR_W + 1)'(SLOT_COUNT));
            s_waddr = clr_ff[SLOT_W-1:0];
            s_wdata = '{inode: 16'd0, offset: 32'd0, next: LINK_NIL, prev: LINK_NIL,
                        refs: 16'd0, cached: 1'b0};
            clr_in  = clr_ff + CLR_W'(1);
         end
         OP_ACCEPT: begin
            cmd_in  = req_cmd;
            slot_in = req_slot;
            key_in  = req_inode_key;
            off_in  = req_file_offset;
            hash_in = pcht_hash(req_inode_key, req_file_offset);
         end
         OP_BKT_RD: begin
            b_re = 1'b1;
         end
         OP_LOAD_HEAD: begin
            ptr_in   = b_rdata_ff;
            steps_in = '0;
         end
         OP_MISS: begin
            res_status_in = ST_MISS;
            res_slot_in   = '0;
            res_refs_in   = '0;
         end
         OP_SLOT_RD_REQ: begin
            s_re = 1'b1;
         end
         OP_SLOT_RD_PTR: begin
            s_re    = 1'b1;
            s_raddr = ptr_ff[SLOT_W-1:0];
         end
         OP_SLOT_RD_PREV: begin
            s_re    = 1'b1;
            s_raddr = rec_ff.prev[SLOT_W-1:0];
         end
         OP_HIT: begin
            mod_rec.refs  = pcht_bump(s_rdata_ff.refs);
            s_we          = 1'b1;
            s_waddr       = ptr_ff[SLOT_W-1:0];
            s_wdata       = mod_rec;
            res_status_in = ST_DONE;
            res_slot_in   = ptr_ff[SLOT_W-1:0];
            res_refs_in   = mod_rec.refs;
         end
         OP_ADVANCE: begin
            ptr_in   = s_rdata_ff.next;
            steps_in = steps_ff + LINK_W'(1);
         end
         OP_HOLD_REC: begin
            rec_in = s_rdata_ff;
         end
         OP_HOLD_REM: begin
            rec_in  = s_rdata_ff;
            hash_in = pcht_hash(s_rdata_ff.inode, s_rdata_ff.offset);
         end
         OP_ILLEGAL: begin
            res_status_in = ST_ILLEGAL;
            res_slot_in   = slot_ff;
            res_refs_in   = s_rdata_ff.refs;
         end
         OP_ADD_WR: begin
            s_we          = 1'b1;
            s_wdata       = '{inode: key_ff, offset: off_ff, next: b_rdata_ff,
                              prev: LINK_NIL, refs: pcht_bump(rec_ff.refs), cached: 1'b1};
            b_we          = 1'b1;
            b_wdata       = slot_link;
            ptr_in        = b_rdata_ff;
            total_in      = total_ff + 10'd1;
            res_status_in = ST_DONE;
            res_slot_in   = slot_ff;
            res_refs_in   = pcht_bump(rec_ff.refs);
         end
         OP_SET_PREV: begin
            mod_rec.prev = (cmd_ff == CMD_ADD) ? slot_link : rec_ff.prev;
            s_we         = 1'b1;
            s_waddr      = ptr_ff[SLOT_W-1:0];
            s_wdata      = mod_rec;
         end
         OP_REM_WR: begin
            s_we          = 1'b1;
            s_wdata       = '{inode: rec_ff.inode, offset: rec_ff.offset, next: LINK_NIL,
                              prev: LINK_NIL, refs: rec_ff.refs, cached: 1'b0};
            ptr_in        = rec_ff.next;
            total_in      = (total_ff != 10'd0) ? total_ff - 10'd1 : total_ff;
            res_status_in = ST_DONE;
            res_slot_in   = slot_ff;
            res_refs_in   = rec_ff.refs;
         end
         OP_SET_NEXT: begin
            mod_rec.next = rec_ff.next;
            s_we         = 1'b1;
            s_waddr      = rec_ff.prev[SLOT_W-1:0];
            s_wdata      = mod_rec;
         end
         OP_BKT_FIX: begin
            b_we    = (b_rdata_ff == slot_link);
            b_wdata = rec_ff.next;
         end
         OP_PUBLISH: begin
            out_status_in = res_status_ff;
            out_slot_in   = res_slot_ff;
            out_refs_in   = res_refs_ff;
            out_total_in  = total_ff;
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   // output beat valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.op == OP_PUBLISH) begin
         out_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      key_ff        <= key_in;
      off_ff        <= off_in;
      hash_ff       <= hash_in;
      ptr_ff        <= ptr_in;
      steps_ff      <= steps_in;
      rec_ff        <= rec_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_refs_ff   <= res_refs_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_refs_ff   <= out_refs_in;
      out_total_ff  <= out_total_in;
   end

   // status to the controller
   always_comb begin
      stat.clr_last   = (clr_ff == CLR_W'(CLR_COUNT - 1));
      stat.is_find    = (cmd_ff == CMD_FIND);
      stat.is_add     = (cmd_ff == CMD_ADD);
      stat.is_rem     = (cmd_ff == CMD_REMOVE);
      stat.cached     = s_rdata_ff.cached;
      stat.match      = (s_rdata_ff.inode == key_ff) && (s_rdata_ff.offset == off_ff);
      stat.ptr_nil    = pcht_is_nil(ptr_ff);
      stat.walk_limit = (steps_ff == LINK_W'(SLOT_COUNT));
      stat.head_nil   = pcht_is_nil(b_rdata_ff);
      stat.nx_nil     = pcht_is_nil(rec_ff.next);
      stat.pv_nil     = pcht_is_nil(rec_ff.prev);
      stat.out_busy   = out_valid_ff && !rsp_ready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_found_slot   = out_slot_ff;
   assign rsp_ref_count    = out_refs_ff;
   assign rsp_cached_pages = out_total_ff;

endmodule

`default_nettype wire

// ----- rtl/pcht_ctrl.sv -----
// controller: sequences clearing, chain walks, link and unlink steps
// depends on pcht_pkg
`default_nettype none

module pcht_ctrl
   import pcht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and micro operation
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_START;
            end
         end
         S_START: begin
            if (stat.is_find) begin
               cmd.op   = OP_BKT_RD;
               state_in = S_FHEAD;
            end else begin
               cmd.op   = OP_SLOT_RD_REQ;
               state_in = S_SCHK;
            end
         end
         // chain walk
         S_FHEAD: begin
            cmd.op   = OP_LOAD_HEAD;
            state_in = S_FRD;
         end
         S_FRD: begin
            if (stat.ptr_nil || stat.walk_limit) begin
               cmd.op   = OP_MISS;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_SLOT_RD_PTR;
               state_in = S_FCMP;
            end
         end
         S_FCMP: begin
            if (stat.match) begin
               cmd.op   = OP_HIT;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_ADVANCE;
               state_in = S_FRD;
            end
         end
         // add or remove legality
         S_SCHK: begin
            if (stat.is_add && !stat.cached) begin
               cmd.op   = OP_HOLD_REC;
               state_in = S_ABKT;
            end else if (stat.is_rem && stat.cached) begin
               cmd.op   = OP_HOLD_REM;
               state_in = S_RUNL;
            end else begin
               cmd.op   = OP_ILLEGAL;
               state_in = S_DONE;
            end
         end
         // link at bucket head
         S_ABKT: begin
            cmd.op   = OP_BKT_RD;
            state_in = S_AWR;
         end
         S_AWR: begin
            cmd.op   = OP_ADD_WR;
            state_in = stat.head_nil ? S_DONE : S_PRD;
         end
         // fix prev link of the follower
         S_PRD: begin
            cmd.op   = OP_SLOT_RD_PTR;
            state_in = S_PWRP;
         end
         S_PWRP: begin
            cmd.op   = OP_SET_PREV;
            state_in = stat.is_add ? S_DONE : S_RPV;
         end
         // unlink
         S_RUNL: begin
            cmd.op   = OP_REM_WR;
            state_in = stat.nx_nil ? S_RPV : S_PRD;
         end
         S_RPV: begin
            if (stat.pv_nil) begin
               state_in = S_RBKT;
            end else begin
               cmd.op   = OP_SLOT_RD_PREV;
               state_in = S_RWN;
            end
         end
         S_RWN: begin
            cmd.op   = OP_SET_NEXT;
            state_in = S_RBKT;
         end
         S_RBKT: begin
            cmd.op   = OP_BKT_RD;
            state_in = S_RBWR;
         end
         S_RBWR: begin
            cmd.op   = OP_BKT_FIX;
            state_in = S_DONE;
         end
         // hand the result to the output register
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.op   = OP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- tb/page_cache_hash_table_top_test.sv -----
// self-checking testbench for the page cache hash table: a directed table, then random traffic
// with an in-bench model of the buckets and slots; depends on pcht_pkg, pcht_if and the top level
`timescale 1ns / 100ps
`default_nettype none

module page_cache_hash_table_top_test;
   import pcht_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int MAX_MISMATCH_PRINT = 10;
   localparam int HOT_KEYS = 24;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [8:0]  slot;
      logic [15:0] inode_key;
      logic [31:0] file_offset;
   } page_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [8:0]  found_slot;
      logic [15:0] ref_count;
      logic [9:0]  cached_pages;
   } page_rsp_type;

   // one directed row: request, plus a typed-in answer where it is obvious
   typedef struct packed {
      page_req_type req;
      logic         fixed;
      page_rsp_type rsp;
   } dir_row_type;

   logic clock;
   logic reset;

   pcht_req_if req_ch ();
   pcht_rsp_if rsp_ch ();

   page_cache_hash_table_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // shadow of the cache
   logic [LINK_W-1:0] head_sh [BUCKETS];
   logic [15:0]       inode_sh [SLOT_COUNT];
   logic [31:0]       offset_sh [SLOT_COUNT];
   logic [LINK_W-1:0] next_sh [SLOT_COUNT];
   logic [LINK_W-1:0] prev_sh [SLOT_COUNT];
   logic [15:0]       refs_sh [SLOT_COUNT];
   logic              cached_sh [SLOT_COUNT];
   logic              written_sh [SLOT_COUNT];
   int unsigned       pages_sh;

   page_rsp_type rsp_pending [$];
   dir_row_type  dir_table [$];
   logic [15:0]  hot_key [HOT_KEYS];
   logic [31:0]  hot_off [HOT_KEYS];
   int           mismatches;
   int           cycle_count;
   bit           long_stall;
   bit           stall_done;

   function automatic logic [HASH_WIDTH-1:0] bucket_index(logic [15:0] key, logic [31:0] off);
      logic [31:0] s;
      s = {16'd0, key} + (off >> PAGE_BITS);
      return HASH_WIDTH'(s + (s >> HASH_WIDTH));
   endfunction

   function automatic logic [15:0] sat_inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   task automatic clear_shadow();
      for (int i = 0; i < BUCKETS; i++) head_sh[i] = LINK_NIL;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         next_sh[i] = LINK_NIL;
         prev_sh[i] = LINK_NIL;
         refs_sh[i] = '0;
         cached_sh[i] = 1'b0;
         written_sh[i] = 1'b0;
         inode_sh[i] = '0;
         offset_sh[i] = '0;
      end
      pages_sh = 0;
   endtask

   // applies one command to the shadow and returns the answer
   function automatic page_rsp_type cache_step(page_req_type r);
      page_rsp_type o;
      int n, steps, h;
      logic [LINK_W-1:0] nx, pv;
      o.status = ST_ILLEGAL;
      o.found_slot = r.slot;
      o.ref_count = '0;
      if (r.cmd == CMD_FIND) begin
         h = bucket_index(r.inode_key, r.file_offset);
         n = head_sh[h];
         steps = 0;
         o.status = ST_MISS;
         o.found_slot = '0;
         while (n < SLOT_COUNT && steps < SLOT_COUNT) begin
            if (inode_sh[n] == r.inode_key && offset_sh[n] == r.file_offset) begin
               refs_sh[n] = sat_inc(refs_sh[n]);
               o.status = ST_DONE;
               o.found_slot = 9'(n);
               o.ref_count = refs_sh[n];
               break;
            end
            n = next_sh[n];
            steps++;
         end
      end else if (r.cmd == CMD_ADD && !cached_sh[r.slot]) begin
         h = bucket_index(r.inode_key, r.file_offset);
         refs_sh[r.slot] = sat_inc(refs_sh[r.slot]);
         inode_sh[r.slot] = r.inode_key;
         offset_sh[r.slot] = r.file_offset;
         written_sh[r.slot] = 1'b1;
         prev_sh[r.slot] = LINK_NIL;
         next_sh[r.slot] = head_sh[h];
         if (head_sh[h] < SLOT_COUNT) prev_sh[head_sh[h]] = LINK_W'(r.slot);
         head_sh[h] = LINK_W'(r.slot);
         cached_sh[r.slot] = 1'b1;
         pages_sh++;
         o.status = ST_DONE;
         o.ref_count = refs_sh[r.slot];
      end else if (r.cmd == CMD_REMOVE && cached_sh[r.slot]) begin
         nx = next_sh[r.slot];
         pv = prev_sh[r.slot];
         h = bucket_index(inode_sh[r.slot], offset_sh[r.slot]);
         next_sh[r.slot] = LINK_NIL;
         prev_sh[r.slot] = LINK_NIL;
         if (nx < SLOT_COUNT) prev_sh[nx] = pv;
         if (pv < SLOT_COUNT) next_sh[pv] = nx;
         if (head_sh[h] == LINK_W'(r.slot)) head_sh[h] = nx;
         cached_sh[r.slot] = 1'b0;
         if (pages_sh > 0) pages_sh--;
         o.status = ST_DONE;
         o.ref_count = refs_sh[r.slot];
      end else begin
         o.ref_count = refs_sh[r.slot];
      end
      o.cached_pages = 10'(pages_sh);
      return o;
   endfunction

   function automatic page_req_type mk_req(logic [1:0] c, logic [8:0] s, logic [15:0] k,
                                           logic [31:0] f);
      page_req_type r;
      r.cmd = c;
      r.slot = s;
      r.inode_key = k;
      r.file_offset = f;
      return r;
   endfunction

   function automatic page_rsp_type mk_rsp(logic [1:0] st, logic [8:0] s, logic [15:0] rc,
                                           logic [9:0] cp);
      page_rsp_type o;
      o.status = st;
      o.found_slot = s;
      o.ref_count = rc;
      o.cached_pages = cp;
      return o;
   endfunction

   task automatic add_row(page_req_type r, logic fx, page_rsp_type o);
      dir_row_type d;
      d.req = r;
      d.fixed = fx;
      d.rsp = o;
      dir_table.push_back(d);
   endtask

   // random request, mostly over a small set of hot pages so finds hit
   function automatic page_req_type rand_req();
      page_req_type r;
      int pick, sel;
      pick = $urandom_range(99);
      sel = $urandom_range(HOT_KEYS - 1);
      r.slot = (pick < 90) ? 9'($urandom_range(63)) : 9'($urandom);
      if (pick < 40) r.cmd = CMD_FIND;
      else if (pick < 70) r.cmd = CMD_ADD;
      else if (pick < 97) r.cmd = CMD_REMOVE;
      else r.cmd = CMD_RSVD;
      if ($urandom_range(9) < 8) begin
         r.inode_key = hot_key[sel];
         r.file_offset = hot_off[sel];
      end else begin
         r.inode_key = 16'($urandom);
         r.file_offset = $urandom;
      end
      // keep the stale page fields of never-written slots out of reach
      if (r.cmd == CMD_REMOVE && !written_sh[r.slot]) r.cmd = CMD_ADD;
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      page_rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = mk_rsp(rsp_ch.status, rsp_ch.found_slot, rsp_ch.ref_count, rsp_ch.cached_pages);
         if (rsp_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_MISMATCH_PRINT)
               $display("unexpected beat: status %0d slot %0d refs %0d pages %0d",
                        got.status, got.found_slot, got.ref_count, got.cached_pages);
         end else begin
            want = rsp_pending.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_MISMATCH_PRINT)
                  $display({"mismatch: exp st %0d sl %0d rc %0d pg %0d,",
                            " got st %0d sl %0d rc %0d pg %0d"},
                           want.status, want.found_slot, want.ref_count, want.cached_pages,
                           got.status, got.found_slot, got.ref_count, got.cached_pages);
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int stall_len;
      rsp_ch.ready = 1'b0;
      stall_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_stall && !stall_done) begin
            rsp_ch.ready = 1'b0;
            repeat (400) @(negedge clock);
            stall_done = 1'b1;
         end
         case ($urandom_range(3))
            0: stall_len = 0;
            1: stall_len = $urandom_range(3);
            default: stall_len = $urandom_range(1);
         endcase
         if (stall_len > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall_len) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         repeat ($urandom_range(12, 1)) @(negedge clock);
      end
   end

   // send one request and record its expected answer at acceptance
   task automatic send_beat(page_req_type r, logic fx, page_rsp_type fixed_rsp);
      page_rsp_type p;
      req_ch.valid = 1'b1;
      req_ch.cmd = r.cmd;
      req_ch.slot = r.slot;
      req_ch.inode_key = r.inode_key;
      req_ch.file_offset = r.file_offset;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      p = cache_step(r);
      rsp_pending.push_back(fx ? fixed_rsp : p);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req_ch.valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clock);
   endtask

   // stimulus
   initial begin
      page_rsp_type none;
      int burst, sent, waited;
      none = '0;
      mismatches = 0;
      long_stall = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_FIND;
      req_ch.slot = '0;
      req_ch.inode_key = '0;
      req_ch.file_offset = '0;
      clear_shadow();
      for (int i = 0; i < HOT_KEYS; i++) begin
         hot_key[i] = (i < 4) ? 16'(i) : 16'($urandom);
         // a few pages share a bucket so chains grow
         hot_off[i] = (i % 3 == 0) ? 32'(i) << PAGE_BITS : $urandom;
      end

      // directed table: extremes, every command, each special case
      add_row(mk_req(CMD_FIND, 9'd0, 16'd0, 32'd0), 1'b1, mk_rsp(ST_MISS, 9'd0, 16'd0, 10'd0));
      add_row(mk_req(CMD_REMOVE, 9'd0, 16'd0, 32'd0), 1'b1,
              mk_rsp(ST_ILLEGAL, 9'd0, 16'd0, 10'd0));
      add_row(mk_req(CMD_ADD, 9'd0, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
              mk_rsp(ST_DONE, 9'd0, 16'd1, 10'd1));
      add_row(mk_req(CMD_ADD, 9'd0, 16'd5, 32'd5), 1'b1,
              mk_rsp(ST_ILLEGAL, 9'd0, 16'd1, 10'd1));
      add_row(mk_req(CMD_FIND, 9'h1FF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
              mk_rsp(ST_DONE, 9'd0, 16'd2, 10'd1));
      add_row(mk_req(CMD_ADD, 9'd511, 16'd0, 32'd0), 1'b1, mk_rsp(ST_DONE, 9'd511, 16'd1, 10'd2));
      // same bucket chain: key 1 offset 0 and key 0 offset one page
      add_row(mk_req(CMD_ADD, 9'd7, 16'd1, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_ADD, 9'd8, 16'd0, 32'h1000), 1'b0, none);
      add_row(mk_req(CMD_ADD, 9'd9, 16'd1, 32'h0FFF), 1'b0, none);
      add_row(mk_req(CMD_FIND, 9'd0, 16'd1, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_REMOVE, 9'd8, 16'd0, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_FIND, 9'd0, 16'd1, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_FIND, 9'd0, 16'd0, 32'h1000), 1'b0, none);
      add_row(mk_req(CMD_REMOVE, 9'd9, 16'd0, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_REMOVE, 9'd7, 16'd0, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_FIND, 9'd0, 16'd1, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_ADD, 9'd7, 16'h5555, 32'hAAAA_AAAA), 1'b0, none);
      add_row(mk_req(CMD_FIND, 9'd0, 16'hAAAA, 32'h5555_5555), 1'b0, none);
      add_row(mk_req(CMD_RSVD, 9'd7, 16'd0, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_RSVD, 9'd100, 16'd0, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_REMOVE, 9'd511, 16'd0, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_REMOVE, 9'd511, 16'd0, 32'd0), 1'b0, none);
      add_row(mk_req(CMD_FIND, 9'd0, 16'd0, 32'd0), 1'b0, none);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i]) send_beat(dir_table[i].req, dir_table[i].fixed, dir_table[i].rsp);
      req_ch.valid = 1'b0;

      // random bursts; a long receiver hold-off partway through
      sent = 0;
      while (sent < 1450) begin
         burst = $urandom_range(20, 1);
         if (sent > 500 && !long_stall) long_stall = 1'b1;
         for (int b = 0; b < burst; b++) begin
            send_beat(rand_req(), 1'b0, none);
            sent++;
         end
         if ($urandom_range(3) != 0) idle_gap();
      end

      req_ch.valid = 1'b0;

      waited = 0;
      while (rsp_pending.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (mismatches == 0 && rsp_pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
